// File: hw/rtl/xca_pkg.sv
package xca_pkg;

  // Adler-32 modulus and header geometry
  localparam logic [16:0] AdlerMod         = 17'd65521;
  localparam int unsigned HeaderBytes      = 16;
  localparam logic [31:0] MaxChunkBytesDef = 32'd16777216;
  localparam logic [23:0] LengthLimitReset = 24'd12582912;
  localparam logic [31:0] SumInit          = 32'h0000_0001;

  // Result queue depth
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StSize     = 2'd1,
    StFlags    = 2'd2,
    StMismatch = 2'd3
  } status_e;

  typedef enum logic {
    KindByte   = 1'b0,
    KindStatus = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_start;
  } in_t;

  typedef struct packed {
    kind_e       out_kind;
    logic [7:0]  out_byte;
    status_e     status;
    logic [31:0] computed_sum;
    logic        last;
  } out_t;

endpackage

// File: hw/rtl/xca_if.sv
// Input byte channel
interface xca_in_if ();
  logic          valid;
  logic          ready;
  xca_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel
interface xca_out_if ();
  logic          valid;
  logic          ready;
  xca_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Length limit write channel
interface xca_cfg_if ();
  logic        valid;
  logic        ready;
  logic [23:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/xor_chunk_adler32_verifier.sv
// Results are registered in the result queue before they are offered; the status
// item after the last payload byte is pushed with its byte item and follows it.
// Throughput: one byte per cycle while in ready is high; the last payload byte yields
// two results; the four-entry queue drains one per cycle while out ready is high.
// Input ready drops while the result queue holds more than two entries.
// Reset (rst_ni low, asynchronous): parser idle, queue empty, sums 1/0,
// length limit back to 12582912.
module xor_chunk_adler32_verifier #(
  parameter logic [31:0] MaxChunkBytes = xca_pkg::MaxChunkBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  xca_in_if.sink   in_i,
  xca_out_if.source out_o,
  xca_cfg_if.sink  cfg_i
);

  localparam int unsigned PtrW = $clog2(xca_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(xca_pkg::QueueDepth + 1);

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhHeader  = 2'd1,
    PhPayload = 2'd2
  } phase_e;

  // Parser state
  phase_e      phase_q, phase_d;
  logic [23:0] pos_q, pos_d;
  logic [31:0] size_q, size_d;
  logic [31:0] flags_q, flags_d;
  logic [31:0] expect_q, expect_d;
  logic [7:0]  key_q, key_d;
  logic [15:0] s1_q, s1_d;
  logic [15:0] s2_q, s2_d;
  logic [23:0] limit_q;

  // Result queue
  xca_pkg::out_t          queue_q [xca_pkg::QueueDepth];
  logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]        count_q;

  logic          in_xfer, out_xfer;
  logic [1:0]    n_res;
  xca_pkg::out_t res0, res1;

  // Effective state after a chunk start
  phase_e      ph_e;
  logic [23:0] pos_e;
  logic [31:0] size_e, flags_e, expect_e;
  logic [7:0]  key_e;
  logic [15:0] s1_e, s2_e;

  logic [3:0]  idx;
  logic [31:0] lane;
  logic [7:0]  dec;
  logic [16:0] s1_sum, s1_red, s2_sum, s2_red;
  logic [24:0] pos_inc;
  logic [31:0] new_sum;

  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_xfer    = out_o.valid && out_o.ready;
  assign in_i.ready  = count_q <= CntW'(xca_pkg::QueueDepth - 2);
  assign out_o.valid = count_q != '0;
  assign out_o.data  = queue_q[rd_ptr_q];
  assign cfg_i.ready = 1'b1;

  // Hold the length limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= xca_pkg::LengthLimitReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      limit_q <= cfg_i.data;
    end
  end

  // Adler-32 step on the decoded byte
  assign dec     = in_i.data.data_byte ^ key_e;
  assign s1_sum  = {1'b0, s1_e} + {9'b0, dec};
  assign s1_red  = (s1_sum >= xca_pkg::AdlerMod) ? s1_sum - xca_pkg::AdlerMod : s1_sum;
  assign s2_sum  = {1'b0, s2_e} + {1'b0, s1_red[15:0]};
  assign s2_red  = (s2_sum >= xca_pkg::AdlerMod) ? s2_sum - xca_pkg::AdlerMod : s2_sum;
  assign new_sum = {s2_red[15:0], s1_red[15:0]};
  assign pos_inc = {1'b0, pos_e} + 25'd1;
  assign idx     = pos_e[3:0];
  assign lane    = {24'b0, in_i.data.data_byte} << {idx[1:0], 3'b000};

  // Parse the header, decode the payload and build the results
  always_comb begin
    ph_e     = phase_q;
    pos_e    = pos_q;
    size_e   = size_q;
    flags_e  = flags_q;
    expect_e = expect_q;
    key_e    = key_q;
    s1_e     = s1_q;
    s2_e     = s2_q;
    if (in_i.data.chunk_start) begin
      ph_e     = PhHeader;
      pos_e    = '0;
      size_e   = '0;
      flags_e  = '0;
      expect_e = '0;
      key_e    = '0;
      s1_e     = 16'd1;
      s2_e     = '0;
    end

    phase_d  = ph_e;
    pos_d    = pos_e;
    size_d   = size_e;
    flags_d  = flags_e;
    expect_d = expect_e;
    key_d    = key_e;
    s1_d     = s1_e;
    s2_d     = s2_e;
    n_res    = 2'd0;

    res0.out_kind     = xca_pkg::KindStatus;
    res0.out_byte     = '0;
    res0.status       = xca_pkg::StOk;
    res0.computed_sum = {s2_e, s1_e};
    res0.last         = 1'b1;
    res1              = res0;

    case (ph_e)
      PhHeader: begin
        case (idx[3:2])
          2'd0:    size_d   = size_e | lane;
          2'd1:    flags_d  = flags_e | lane;
          2'd2:    expect_d = expect_e | lane;
          default: if (idx[1:0] == 2'd0) key_d = in_i.data.data_byte;
        endcase
        pos_d = 24'(idx) + 24'd1;
        if (idx == 4'(xca_pkg::HeaderBytes - 1)) begin
          pos_d = '0;
          if (size_d > {8'b0, limit_q} || size_d > MaxChunkBytes) begin
            n_res       = 2'd1;
            res0.status = xca_pkg::StSize;
            phase_d     = PhIdle;
          end else if (flags_d != '0) begin
            n_res       = 2'd1;
            res0.status = xca_pkg::StFlags;
            phase_d     = PhIdle;
          end else if (size_d == '0) begin
            n_res       = 2'd1;
            res0.status = ({s2_e, s1_e} == expect_d) ? xca_pkg::StOk
                                                     : xca_pkg::StMismatch;
            phase_d     = PhIdle;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        s1_d              = s1_red[15:0];
        s2_d              = s2_red[15:0];
        n_res             = 2'd1;
        res0.out_kind     = xca_pkg::KindByte;
        res0.out_byte     = dec;
        res0.computed_sum = new_sum;
        res0.last         = 1'b0;
        pos_d             = pos_inc[23:0];
        if (pos_inc >= {1'b0, size_e[23:0]}) begin
          n_res             = 2'd2;
          res1.computed_sum = new_sum;
          res1.status       = (new_sum == expect_e) ? xca_pkg::StOk
                                                    : xca_pkg::StMismatch;
          phase_d           = PhIdle;
          pos_d             = '0;
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
  end

  // Advance the parser on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      pos_q    <= '0;
      size_q   <= '0;
      flags_q  <= '0;
      expect_q <= '0;
      key_q    <= '0;
      s1_q     <= 16'd1;
      s2_q     <= '0;
    end else if (in_xfer) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      size_q   <= size_d;
      flags_q  <= flags_d;
      expect_q <= expect_d;
      key_q    <= key_d;
      s1_q     <= s1_d;
      s2_q     <= s2_d;
    end
  end

  // Push results into the queue
  always_ff @(posedge clk_i) begin
    if (in_xfer && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (in_xfer && n_res == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  // Track queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(in_xfer ? n_res : 2'd0);
      end
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(in_xfer ? n_res : 2'd0) - CntW'(out_xfer);
    end
  end

endmodule

// File: hw/rtl/xca_checker.sv
module xca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input xca_pkg::out_t out_data_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  // Mark only status items as last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.last == (out_data_i.out_kind == xca_pkg::KindStatus)))
    else $error("last flag disagrees with item kind");

  // Keep unused fields clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.out_kind == xca_pkg::KindStatus) ? out_data_i.out_byte == '0
                                                    : out_data_i.status == xca_pkg::StOk)
    else $error("unused result field not zero");

  // Keep both sums reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> {1'b0, out_data_i.computed_sum[15:0]} < xca_pkg::AdlerMod &&
                    {1'b0, out_data_i.computed_sum[31:16]} < xca_pkg::AdlerMod)
    else $error("Adler sum out of range");

  // Header rejections carry the initial sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == xca_pkg::StSize ||
                    out_data_i.status == xca_pkg::StFlags)
    |-> out_data_i.computed_sum == xca_pkg::SumInit)
    else $error("rejected chunk reports a non-initial sum");

endmodule

bind xor_chunk_adler32_verifier xca_checker u_xca_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
